// ===== rtl/core/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg: shared types for the selective-repeat sender window
// Command codes, control states and the result beat layout.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int PORT_SEQ_W  = 16;
	localparam int PORT_DATA_W = 64;

	typedef enum logic [1:0] {
		CMD_SEND   = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_EXPIRE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_EVAL,
		ST_SLIDE,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                   accepted;
		logic                   transmit;
		logic [PORT_SEQ_W-1:0]  tx_seq;
		logic [PORT_DATA_W-1:0] tx_data;
		logic                   start_timer;
		logic                   stop_timer;
		logic [PORT_SEQ_W-1:0]  timer_seq;
	} result_t;

endpackage

// ===== rtl/core/selective_repeat_sender_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: selective-repeat ARQ sender
// Buffers unacknowledged words, tracks ACK marks, base and next sequence
// numbers, and answers each event beat with one result beat.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | command, data_word, ack_seq, ack_intact,
//          |                     | expired_seq
//  out     | out_valid/out_ready | accepted, transmit, tx_seq, tx_data,
//          |                     | start_timer, stop_timer, timer_seq,
//          |                     | window_full, window_base
//
//  Path per beat, the same for any BUF_DEPTH: send, bad ACK and unused code
//    pass idle, eval and done; an intact ACK or a timeout adds the slot
//    lookup, an ACK at the base adds the slide over each acked slot, and a
//    resent timeout adds a buffer read. The lookup is registered at any depth.
//  One event in flight; in_ready is high in idle even while a result waits.
//  Reset clears base, next, full flag and all ACK marks at once; the payload
//  buffer needs no clearing (a slot is read only after a send wrote it).
//  A stalled output holds the finished event in the done state.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window
	import srsw_pkg::*;
#(
	parameter int WINDOW    = 4,
	parameter int BUF_DEPTH = 8,
	parameter int SEQ_BITS  = 16,
	parameter int DATA_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [PORT_DATA_W-1:0] data_word,
	input  logic [PORT_SEQ_W-1:0]  ack_seq,
	input  logic                   ack_intact,
	input  logic [PORT_SEQ_W-1:0]  expired_seq,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   accepted,
	output logic                   transmit,
	output logic [PORT_SEQ_W-1:0]  tx_seq,
	output logic [PORT_DATA_W-1:0] tx_data,
	output logic                   start_timer,
	output logic                   stop_timer,
	output logic [PORT_SEQ_W-1:0]  timer_seq,
	output logic                   window_full,
	output logic [PORT_SEQ_W-1:0]  window_base
);

	localparam int SLOT_W = $clog2(BUF_DEPTH);
	// wide enough for any outstanding count and for WINDOW itself
	localparam int CMPW   = SEQ_BITS + 6;
	localparam logic [CMPW-1:0] WIN_C = CMPW'(WINDOW);

	// window state
	logic [SEQ_BITS-1:0]  base_q, next_q;
	logic [SLOT_W-1:0]    base_slot_q, next_slot_q;
	logic                 full_q;
	logic [BUF_DEPTH-1:0] acked_q;

	// event held while it is worked on
	state_t               state_q, state_d;
	logic [1:0]           cmd_q;
	logic [DATA_BITS-1:0] data_q;
	logic [SEQ_BITS-1:0]  seq_q;
	logic                 intact_q;
	result_t              res_q;

	// output register
	result_t              out_q;
	logic                 out_valid_q;
	logic                 out_full_q;
	logic [SEQ_BITS-1:0]  out_base_q;

	// control
	logic                 need_slot, in_fire, slot_start, slot_done, out_load;
	logic [SLOT_W-1:0]    slot_res;
	logic                 mem_we, mem_re;
	logic [DATA_BITS-1:0] mem_rdata;
	logic [SEQ_BITS-1:0]  outs, off, outs_inc;
	logic                 in_win, can_send, full_set, mark_hit;
	logic                 ack_base, ack_other, exp_ok, slide_go;

	// next slot tracks seq+1 without a divider: a sequence wrap restarts at 0
	function automatic logic [SLOT_W-1:0] inc_slot(input logic [SEQ_BITS-1:0] s,
		input logic [SLOT_W-1:0] sl);
		logic [SLOT_W-1:0] r;
		if (s == '1) begin
			r = '0;
		end else if (sl == SLOT_W'(BUF_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = sl + 1'b1;
		end
		return r;
	endfunction

	srsw_slot #(
		.BUF_DEPTH(BUF_DEPTH),
		.SEQ_BITS (SEQ_BITS)
	) u_slot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (slot_start),
		.seq      ((command == CMD_EXPIRE) ? SEQ_BITS'(expired_seq) : SEQ_BITS'(ack_seq)),
		.base     (base_q),
		.base_slot(base_slot_q),
		.done     (slot_done),
		.slot     (slot_res)
	);

	// sends write, timeouts read; one event at a time, so no same-slot overlap
	srsw_buf #(
		.DEPTH(BUF_DEPTH),
		.WIDTH(DATA_BITS)
	) u_buf (
		.clk  (clk),
		.we   (mem_we),
		.waddr(next_slot_q),
		.wdata(data_q),
		.re   (mem_re),
		.raddr(slot_res),
		.rdata(mem_rdata)
	);

	// --- modular window checks ---
	always_comb begin
		outs      = next_q - base_q;
		off       = seq_q - base_q;
		outs_inc  = outs + 1'b1;
		in_win    = off < outs;
		can_send  = !full_q && (CMPW'(outs) < WIN_C);
		full_set  = CMPW'(outs_inc) >= WIN_C;
		mark_hit  = acked_q[slot_res];
		ack_base  = (cmd_q == CMD_ACK) && intact_q && in_win && (off == '0);
		ack_other = (cmd_q == CMD_ACK) && intact_q && in_win && (off != '0) && !mark_hit;
		exp_ok    = (cmd_q == CMD_EXPIRE) && in_win && !mark_hit;
		slide_go  = (base_q != next_q) && acked_q[base_slot_q];
		need_slot = ((command == CMD_ACK) && ack_intact) || (command == CMD_EXPIRE);
	end

	// --- next state ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = need_slot ? ST_SLOT : ST_EVAL;
				end
			end
			ST_SLOT: begin
				if (slot_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (ack_base) begin
					state_d = ST_SLIDE;
				end else if (exp_ok) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SLIDE: begin
				if (!slide_go) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// --- control outputs ---
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		in_fire    = in_valid && in_ready;
		slot_start = in_fire && need_slot;
		mem_we     = (state_q == ST_EVAL) && (cmd_q == CMD_SEND) && can_send;
		mem_re     = (state_q == ST_EVAL) && exp_ok;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// --- state and window registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			full_q      <= 1'b0;
			acked_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL) begin
				unique case (cmd_q)
					CMD_SEND: begin
						if (can_send) begin
							acked_q[next_slot_q] <= 1'b0;
							next_q               <= next_q + 1'b1;
							next_slot_q          <= inc_slot(next_q, next_slot_q);
							if (full_set) begin
								full_q <= 1'b1;
							end
						end
					end
					CMD_ACK: begin
						if (ack_base || ack_other) begin
							acked_q[slot_res] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			// base slides one slot per cycle over consecutive marks
			if (state_q == ST_SLIDE) begin
				if (slide_go) begin
					acked_q[base_slot_q] <= 1'b0;
					base_q               <= base_q + 1'b1;
					base_slot_q          <= inc_slot(base_q, base_slot_q);
				end else begin
					full_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// --- event and result payload ---
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q    <= command;
			data_q   <= DATA_BITS'(data_word);
			seq_q    <= (command == CMD_EXPIRE) ? SEQ_BITS'(expired_seq)
				: SEQ_BITS'(ack_seq);
			intact_q <= ack_intact;
			res_q    <= '0;
		end
		if (state_q == ST_EVAL) begin
			if (mem_we) begin
				res_q.accepted    <= 1'b1;
				res_q.transmit    <= 1'b1;
				res_q.tx_seq      <= PORT_SEQ_W'(next_q);
				res_q.tx_data     <= PORT_DATA_W'(data_q);
				res_q.start_timer <= 1'b1;
				res_q.timer_seq   <= PORT_SEQ_W'(next_q);
			end
			if (ack_base || ack_other) begin
				res_q.stop_timer <= 1'b1;
				res_q.timer_seq  <= PORT_SEQ_W'(seq_q);
			end
			// retransmit: restart the timer with stop and start together
			if (exp_ok) begin
				res_q.transmit    <= 1'b1;
				res_q.tx_seq      <= PORT_SEQ_W'(seq_q);
				res_q.start_timer <= 1'b1;
				res_q.stop_timer  <= 1'b1;
				res_q.timer_seq   <= PORT_SEQ_W'(seq_q);
			end
		end
		if (state_q == ST_READ) begin
			res_q.tx_data <= PORT_DATA_W'(mem_rdata);
		end
		if (out_load) begin
			out_q      <= res_q;
			out_full_q <= full_q;
			out_base_q <= base_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = out_q.accepted;
	assign transmit    = out_q.transmit;
	assign tx_seq      = out_q.tx_seq;
	assign tx_data     = out_q.tx_data;
	assign start_timer = out_q.start_timer;
	assign stop_timer  = out_q.stop_timer;
	assign timer_seq   = out_q.timer_seq;
	assign window_full = out_full_q;
	assign window_base = PORT_SEQ_W'(out_base_q);

	a_outs_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(outs) <= WIN_C || WIN_C > CMPW'({SEQ_BITS{1'b1}}))
		else $error("more packets outstanding than the window allows");

	a_full_means_window: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && state_q != ST_SLIDE) |-> CMPW'(outs) == WIN_C)
		else $error("full flag set with room in the window");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

endmodule

// ===== rtl/core/srsw_slot.sv =====
// ----------------------------------------------------------------------------
// srsw_slot: sequence number to buffer slot
// Slot = seq mod BUF_DEPTH, registered when start is high. Power-of-two
// depth: low bits. Other depths: built from the offset to the window base.
// ----------------------------------------------------------------------------
module srsw_slot
	import srsw_pkg::*;
#(
	parameter int BUF_DEPTH = 8,
	parameter int SEQ_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SEQ_BITS-1:0]          seq,
	input  logic [SEQ_BITS-1:0]          base,
	input  logic [$clog2(BUF_DEPTH)-1:0] base_slot,
	output logic                         done,
	output logic [$clog2(BUF_DEPTH)-1:0] slot
);

	localparam int SLOT_W  = $clog2(BUF_DEPTH);
	localparam int SMALL_W = 7;
	localparam bit POW2    = (BUF_DEPTH & (BUF_DEPTH - 1)) == 0;

	logic [SLOT_W-1:0]   rem_q;
	logic                done_q;
	logic [SEQ_BITS-1:0] off;
	logic [SMALL_W-1:0]  x_lo;
	logic [SLOT_W-1:0]   slot_d;

	// x mod BUF_DEPTH for x below 128, a constant table
	function automatic logic [SLOT_W-1:0] mod_small(input logic [SMALL_W-1:0] x);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << SMALL_W); i++) begin
			if (x == SMALL_W'(i)) begin
				r = SLOT_W'(i % BUF_DEPTH);
			end
		end
		return r;
	endfunction

	// inside the window the offset is below 32, so base_slot + offset < 96;
	// past the sequence wrap seq itself is below the offset
	always_comb begin
		off  = seq - base;
		x_lo = (seq < base) ? SMALL_W'(seq) : SMALL_W'(base_slot) + SMALL_W'(off);
		if (POW2) begin
			slot_d = SLOT_W'(seq);
		end else begin
			slot_d = mod_small(x_lo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				rem_q <= slot_d;
			end
		end
	end

	assign done = done_q;
	assign slot = rem_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {1'b0, slot} < (SLOT_W+1)'(BUF_DEPTH))
		else $error("slot out of buffer range");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("slot done without a start");

endmodule

// ===== rtl/core/srsw_buf.sv =====
// ----------------------------------------------------------------------------
// srsw_buf: payload buffer
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srsw_buf
	import srsw_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== verif/tb_selective_repeat_sender_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window: self-checking bench for the ARQ sender
// Drives send, ACK and timeout events through the valid/ready input channel.
// A behavioral window predictor works out each result beat when its event is
// accepted, and a scoreboard compares every result beat field by field.
// Covers window fill, the ACK and timeout corner cases, rounds of full
// windows acked in shuffled order, and random traffic under several idle
// and stall mixes.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window;
	import srsw_pkg::*;

	localparam int WINDOW    = 4;
	localparam int BUF_DEPTH = 8;

	// spare command code: block only reports the window state
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int WINDOW_ROUNDS   = 30;	// full windows filled and acked
	localparam int ITEMS_PER_PHASE = 300;	// events per idle/stall mix
	localparam int DRAIN_CYCLES    = 20;	// worst event latency plus margin
	localparam int STALL_LIMIT     = 4000;	// cycles with no beat on either side

	// expected result beat: package result fields plus the window state
	typedef struct packed {
		result_t                beat;
		logic                   full;
		logic [PORT_SEQ_W-1:0]  base;
	} outcome_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic [1:0]             command     = CMD_SEND;
	logic [PORT_DATA_W-1:0] data_word   = '0;
	logic [PORT_SEQ_W-1:0]  ack_seq     = '0;
	logic                   ack_intact  = 1'b0;
	logic [PORT_SEQ_W-1:0]  expired_seq = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic                   accepted;
	logic                   transmit;
	logic [PORT_SEQ_W-1:0]  tx_seq;
	logic [PORT_DATA_W-1:0] tx_data;
	logic                   start_timer;
	logic                   stop_timer;
	logic [PORT_SEQ_W-1:0]  timer_seq;
	logic                   window_full;
	logic [PORT_SEQ_W-1:0]  window_base;

	// predictor state, advanced at each accepted input beat
	logic [PORT_SEQ_W-1:0]  base_q = '0;
	logic [PORT_SEQ_W-1:0]  next_q = '0;
	logic                   full_q = 1'b0;
	logic                   acked_q [BUF_DEPTH];
	logic [PORT_DATA_W-1:0] words_q [BUF_DEPTH];

	outcome_t pending_outcomes [$];
	outcome_t want;
	int       mismatch_count  = 0;
	int       item_count      = 0;	// input beats accepted so far
	int       quiet_cycles    = 0;
	int       idle_pct        = 0;	// chance the sender holds off per cycle
	int       stall_pct       = 0;	// chance the receiver drops ready per cycle

	selective_repeat_sender_window #(
		.WINDOW   (WINDOW),
		.BUF_DEPTH(BUF_DEPTH),
		.SEQ_BITS (PORT_SEQ_W),
		.DATA_BITS(PORT_DATA_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.data_word  (data_word),
		.ack_seq    (ack_seq),
		.ack_intact (ack_intact),
		.expired_seq(expired_seq),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.transmit   (transmit),
		.tx_seq     (tx_seq),
		.tx_data    (tx_data),
		.start_timer(start_timer),
		.stop_timer (stop_timer),
		.timer_seq  (timer_seq),
		.window_full(window_full),
		.window_base(window_base)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [PORT_DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [PORT_SEQ_W-1:0] rand16();
		return PORT_SEQ_W'($urandom_range(16'hFFFF));
	endfunction

	// Window behavior: one event in, one result out. All sequence distances
	// are taken mod 2^16 so the window works across the wrap point.
	function automatic outcome_t predict_outcome(input logic [1:0] cmd,
			input logic [PORT_DATA_W-1:0] data, input logic [PORT_SEQ_W-1:0] ack,
			input logic intact, input logic [PORT_SEQ_W-1:0] expd);
		outcome_t               o;
		logic [PORT_SEQ_W-1:0]  outs;
		logic [PORT_SEQ_W-1:0]  off;
		int                     s;
		o = '0;
		outs = next_q - base_q;
		case (cmd)
		CMD_SEND: begin
			// taken only with room in the window
			if (!full_q && outs < WINDOW) begin
				s = next_q % BUF_DEPTH;
				words_q[s] = data;
				acked_q[s] = 1'b0;
				o.beat.accepted    = 1'b1;
				o.beat.transmit    = 1'b1;
				o.beat.tx_seq      = next_q;
				o.beat.tx_data     = data;
				o.beat.start_timer = 1'b1;
				o.beat.timer_seq   = next_q;
				next_q = next_q + 16'd1;
				if (PORT_SEQ_W'(next_q - base_q) >= WINDOW)
					full_q = 1'b1;
			end
		end
		CMD_ACK: begin
			// bad checksum, out of window and duplicate ACKs fall through
			off = ack - base_q;
			s = ack % BUF_DEPTH;
			if (intact && off < outs && off == 0) begin
				o.beat.stop_timer = 1'b1;
				o.beat.timer_seq  = ack;
				acked_q[s] = 1'b1;
				// slide past every consecutive acknowledged slot
				while (base_q != next_q && acked_q[base_q % BUF_DEPTH]) begin
					acked_q[base_q % BUF_DEPTH] = 1'b0;
					base_q = base_q + 16'd1;
				end
				full_q = 1'b0;
			end else if (intact && off < outs && !acked_q[s]) begin
				o.beat.stop_timer = 1'b1;
				o.beat.timer_seq  = ack;
				acked_q[s] = 1'b1;
			end
		end
		CMD_EXPIRE: begin
			// resend only an outstanding, unacknowledged packet
			off = expd - base_q;
			s = expd % BUF_DEPTH;
			if (off < outs && !acked_q[s]) begin
				o.beat.stop_timer  = 1'b1;
				o.beat.start_timer = 1'b1;
				o.beat.timer_seq   = expd;
				o.beat.transmit    = 1'b1;
				o.beat.tx_seq      = expd;
				o.beat.tx_data     = words_q[s];
			end
		end
		default: begin
		end
		endcase
		o.full = full_q;
		o.base = base_q;
		return o;
	endfunction

	// Present one event, hold it until accepted, then log its expected result.
	// Valid stays high between back-to-back beats; it only drops for idle gaps.
	task automatic send_event(input logic [1:0] cmd, input logic [PORT_DATA_W-1:0] data,
			input logic [PORT_SEQ_W-1:0] ack, input logic intact,
			input logic [PORT_SEQ_W-1:0] expd);
		outcome_t o;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		data_word   <= data;
		ack_seq     <= ack;
		ack_intact  <= intact;
		expired_seq <= expd;
		do
			@(posedge clk);
		while (!in_ready);
		o = predict_outcome(cmd, data, ack, intact, expd);
		item_count++;
		pending_outcomes.push_back(o);
	endtask

	// caller must have lowered valid in this step
	task automatic wait_for_results();
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Fill the window with extreme payloads, then one send while full.
	task automatic test_fill_window();
		send_event(CMD_SEND, 64'h0, rand16(), 1'b1, rand16());
		send_event(CMD_SEND, 64'hFFFF_FFFF_FFFF_FFFF, rand16(), 1'b0, rand16());
		send_event(CMD_SEND, 64'hAAAA_AAAA_AAAA_AAAA, rand16(), 1'b1, rand16());
		send_event(CMD_SEND, 64'h5555_5555_5555_5555, rand16(), 1'b0, rand16());
		send_event(CMD_SEND, rand64(), rand16(), 1'b1, rand16());
	endtask

	// ACK and timeout corner cases on a full window, then a multi-slot slide.
	task automatic test_ack_rules();
		logic [PORT_SEQ_W-1:0] b;
		logic [PORT_SEQ_W-1:0] n;
		b = base_q;
		n = next_q;
		send_event(CMD_ACK, rand64(), b, 1'b0, rand16());		// bad checksum
		send_event(CMD_ACK, rand64(), n, 1'b1, rand16());		// one past window
		send_event(CMD_ACK, rand64(), 16'hFFFF, 1'b1, 16'hFFFF);	// far outside
		send_event(CMD_ACK, rand64(), b + 16'd2, 1'b1, rand16());	// out of order
		send_event(CMD_ACK, rand64(), b + 16'd2, 1'b1, rand16());	// duplicate
		send_event(CMD_EXPIRE, rand64(), rand16(), 1'b1, b + 16'd2);	// already acked
		send_event(CMD_EXPIRE, rand64(), rand16(), 1'b0, b + 16'd1);	// retransmit
		send_event(CMD_EXPIRE, rand64(), rand16(), 1'b1, n);		// not outstanding
		send_event(CMD_EXPIRE, rand64(), 16'h0, 1'b1, 16'hFFFF);
		send_event(CMD_UNUSED, rand64(), rand16(), 1'b1, rand16());
		// hold off until the block has answered everything
		in_valid <= 1'b0;
		wait_for_results();
		send_event(CMD_ACK, rand64(), b, 1'b1, rand16());		// slide by one
		send_event(CMD_ACK, rand64(), b + 16'd3, 1'b1, rand16());
		send_event(CMD_ACK, rand64(), b + 16'd1, 1'b1, rand16());	// slide to next
	endtask

	// Fill the window and ack it in shuffled order, back to back, for a
	// number of rounds.
	task automatic test_window_rounds();
		int                     order [WINDOW];
		int                     n;
		int                     j;
		int                     t;
		logic [PORT_SEQ_W-1:0]  b;
		for (int r = 0; r < WINDOW_ROUNDS; r++) begin
			while (!full_q)
				send_event(CMD_SEND, rand64(), rand16(), 1'b0, rand16());
			b = base_q;
			n = PORT_SEQ_W'(next_q - base_q);
			for (int i = 0; i < n; i++)
				order[i] = i;
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			for (int i = 0; i < n; i++)
				send_event(CMD_ACK, rand64(), b + PORT_SEQ_W'(order[i]), 1'b1, rand16());
		end
	endtask

	// Mostly protocol-shaped events aimed inside the window, some noise.
	task automatic random_event();
		logic [PORT_SEQ_W-1:0]  outs;
		logic [PORT_SEQ_W-1:0]  pick;
		int                     r;
		outs = next_q - base_q;
		pick = base_q;
		if (outs != 0)
			pick = base_q + PORT_SEQ_W'($urandom_range(outs - 1));
		r = $urandom_range(99);
		if (r < 35)
			send_event(CMD_SEND, rand64(), rand16(), 1'($urandom_range(1)), rand16());
		else if (r < 60)
			send_event(CMD_ACK, rand64(), pick, 1'b1, rand16());
		else if (r < 70)
			send_event(CMD_ACK, rand64(), base_q, 1'b1, rand16());
		else if (r < 80)
			send_event(CMD_EXPIRE, rand64(), rand16(), 1'($urandom_range(1)), pick);
		else if (r < 85)
			send_event(CMD_ACK, rand64(), pick, 1'b0, rand16());
		else if (r < 90)
			send_event(CMD_ACK, rand64(), next_q, 1'b1, next_q);
		else
			send_event(2'($urandom_range(3)), rand64(), rand16(),
				1'($urandom_range(1)), rand16());
	endtask

	// Random traffic under four handshake mixes.
	task automatic test_random_traffic();
		int idle_mix  [4];
		int stall_mix [4];
		int start;
		idle_mix  = '{0, 66, 0, 19};
		stall_mix = '{0, 0, 66, 19};
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_mix[p];
			stall_pct = stall_mix[p];
			start = item_count;
			while (item_count - start < ITEMS_PER_PHASE)
				random_event();
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	function automatic void check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			mismatch_count++;
		end
	endfunction

	// result sink: ready toggles at random per the current stall mix
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(99) >= stall_pct;
	end

	// scoreboard: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no event outstanding");
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("accepted", 64'(want.beat.accepted), 64'(accepted));
				check_field("transmit", 64'(want.beat.transmit), 64'(transmit));
				check_field("tx_seq", 64'(want.beat.tx_seq), 64'(tx_seq));
				check_field("tx_data", want.beat.tx_data, tx_data);
				check_field("start_timer", 64'(want.beat.start_timer), 64'(start_timer));
				check_field("stop_timer", 64'(want.beat.stop_timer), 64'(stop_timer));
				check_field("timer_seq", 64'(want.beat.timer_seq), 64'(timer_seq));
				check_field("window_full", 64'(want.full), 64'(window_full));
				check_field("window_base", 64'(want.base), 64'(window_base));
			end
		end
	end

	// watchdog: too long with no beat on either channel means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < BUF_DEPTH; i++)
			acked_q[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_window();
		test_ack_rules();
		test_window_rounds();
		test_random_traffic();

		in_valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/srsw_pkg.sv
rtl/core/srsw_slot.sv
rtl/core/srsw_buf.sv
rtl/core/selective_repeat_sender_window.sv
verif/tb_selective_repeat_sender_window.sv
